### rtl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants for the text console character engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int MAX_COLS_DEF = 80;
    localparam int MAX_ROWS_DEF = 25;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int OFF_W  = 11;
    localparam int LIN_W  = COL_W + ROW_W;

    localparam logic [COL_W-1:0] COLUMNS_RST = 7'd80;
    localparam logic [ROW_W-1:0] ROWS_RST    = 5'd25;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_MOVE  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic {
        REG_COLUMNS = 1'b0,
        REG_ROWS    = 1'b1
    } t_reg_idx;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_COPY,
        ST_FILL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic we;
        logic re;
    } t_grid_ctl;

endpackage

### rtl/tcce_grid.sv
// ----------------------------------------------------------------------------
// tcce_grid
// Character store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcce_grid #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                       i_clk,
    input  tcce_pkg::t_grid_ctl        i_ctl,
    input  logic [AW-1:0]              i_waddr,
    input  logic [tcce_pkg::CHAR_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic [tcce_pkg::CHAR_W-1:0] o_rdata
);
    import tcce_pkg::*;

    logic [CHAR_W-1:0] r_mem [DEPTH];
    logic [CHAR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/text_console_char_engine.sv
// ----------------------------------------------------------------------------
// text_console_char_engine
// Teletype-style character engine over a scrolling character grid.
// ----------------------------------------------------------------------------
// After reset the block clears its MAX_COLS*MAX_ROWS cell store, one cell a
// cycle, and stalls input until the clear is done. A put without scroll and
// a move pass through EXEC and DONE, and a read through EXEC, READ and DONE,
// before the result goes to the output register. A put that scrolls first
// copies every row but the top one up by one row and then fills the bottom
// row with spaces, and a clear fills all MAX_COLS*MAX_ROWS cells with zero;
// both use the single address counter and the one write port of the store.
// One item is in work at a time; a finished result waits in the output
// register while the next beat is taken.
module text_console_char_engine #(
    parameter int MAX_COLS = tcce_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tcce_pkg::MAX_ROWS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [tcce_pkg::COL_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_cmd,
    input  logic [tcce_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcce_pkg::COL_W-1:0]   i_col,
    input  logic [tcce_pkg::ROW_W-1:0]   i_row,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [tcce_pkg::COL_W-1:0]   o_cursor_col,
    output logic [tcce_pkg::ROW_W-1:0]   o_cursor_row,
    output logic [tcce_pkg::OFF_W-1:0]   o_cursor_offset,
    output logic [tcce_pkg::CHAR_W-1:0]  o_read_char,
    output logic                         o_scrolled
);
    import tcce_pkg::*;

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    function automatic logic [COL_W-1:0] sat_col(input logic [COL_W-1:0] v,
                                                 input logic [COL_W-1:0] lim);
        return (v >= lim) ? lim - 7'd1 : v;
    endfunction

    function automatic logic [ROW_W-1:0] sat_row(input logic [ROW_W-1:0] v,
                                                 input logic [ROW_W-1:0] lim);
        return (v >= lim) ? lim - 5'd1 : v;
    endfunction

    t_state              r_state, n_state;
    t_state              r_after, n_after;
    t_cmd                r_cmd, n_cmd;
    logic [CHAR_W-1:0]   r_ch, n_ch;
    logic [COL_W-1:0]    r_col_in, n_col_in;
    logic [ROW_W-1:0]    r_row_in, n_row_in;
    logic [COL_W-1:0]    r_cur_col, n_cur_col;
    logic [ROW_W-1:0]    r_cur_row, n_cur_row;
    logic [COL_W-1:0]    r_columns, n_columns;
    logic [ROW_W-1:0]    r_rows, n_rows;
    logic [CW-1:0]       r_ra, n_ra;
    logic [CW-1:0]       r_lim, n_lim;
    logic [AW-1:0]       r_pa, n_pa;
    logic                r_pend, n_pend;
    logic [CHAR_W-1:0]   r_fill_data, n_fill_data;
    logic                r_scr, n_scr;
    logic [CHAR_W-1:0]   r_rd, n_rd;
    logic                r_out_valid, n_out_valid;
    logic [COL_W-1:0]    r_out_col, n_out_col;
    logic [ROW_W-1:0]    r_out_row, n_out_row;
    logic [OFF_W-1:0]    r_out_off, n_out_off;
    logic [CHAR_W-1:0]   r_out_rd, n_out_rd;
    logic                r_out_scr, n_out_scr;

    logic [COL_W-1:0]    nc;
    logic [ROW_W-1:0]    nr;
    logic [COL_W-1:0]    col_s, in_col_s, mul_col;
    logic [ROW_W-1:0]    row_s, in_row_s, mul_row;
    logic [LIN_W-1:0]    prod, lin;
    logic [CW-1:0]       ra_inc;
    logic [COL_W:0]      put_col;
    logic [ROW_W:0]      put_row;
    logic                put_we, put_scroll;
    logic [CHAR_W-1:0]   put_data;
    t_grid_ctl           grid_ctl;
    logic [AW-1:0]       waddr, raddr;
    logic [CHAR_W-1:0]   wdata, rdata;

    always_comb begin
        if (r_columns == '0) begin
            nc = 7'd1;
        end else if (int'(r_columns) > MAX_COLS) begin
            nc = COL_W'(MAX_COLS);
        end else begin
            nc = r_columns;
        end
        if (r_rows == '0) begin
            nr = 5'd1;
        end else if (int'(r_rows) > MAX_ROWS) begin
            nr = ROW_W'(MAX_ROWS);
        end else begin
            nr = r_rows;
        end
    end

    assign col_s    = sat_col(r_cur_col, nc);
    assign row_s    = sat_row(r_cur_row, nr);
    assign in_col_s = sat_col(r_col_in, nc);
    assign in_row_s = sat_row(r_row_in, nr);

    // shared row * columns + column unit
    always_comb begin
        if (r_state == ST_EXEC && r_cmd == CMD_READ) begin
            mul_row = in_row_s;
            mul_col = in_col_s;
        end else if (r_state == ST_EXEC) begin
            mul_row = row_s;
            mul_col = col_s;
        end else begin
            mul_row = r_cur_row;
            mul_col = r_cur_col;
        end
    end

    assign prod   = LIN_W'({{COL_W{1'b0}}, mul_row} * {{ROW_W{1'b0}}, nc});
    assign lin    = prod + LIN_W'(mul_col);
    assign ra_inc = r_ra + CW'(1);

    always_comb begin
        put_col    = {1'b0, col_s};
        put_row    = {1'b0, row_s};
        put_we     = 1'b0;
        put_data   = CH_DOT;
        put_scroll = 1'b0;
        case (r_ch)
            CH_BS: begin
                if (col_s != '0) begin
                    put_col = {1'b0, col_s - 7'd1};
                end
            end
            CH_CR: begin
                put_col = '0;
            end
            CH_LF: begin
                put_col = '0;
                put_row = {1'b0, row_s} + 6'd1;
            end
            default: begin
                put_we = 1'b1;
                if (r_ch >= CH_SPACE) begin
                    put_data = r_ch;
                    put_col  = {1'b0, col_s} + 8'd1;
                end
            end
        endcase
        if (put_col >= {1'b0, nc}) begin
            put_col = '0;
            put_row = put_row + 6'd1;
        end
        if (put_row >= {1'b0, nr}) begin
            put_scroll = 1'b1;
            put_row    = {1'b0, nr - 5'd1};
        end
    end

    always_comb begin
        n_state     = r_state;
        n_after     = r_after;
        n_cmd       = r_cmd;
        n_ch        = r_ch;
        n_col_in    = r_col_in;
        n_row_in    = r_row_in;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_columns   = r_columns;
        n_rows      = r_rows;
        n_ra        = r_ra;
        n_lim       = r_lim;
        n_pa        = r_pa;
        n_pend      = r_pend;
        n_fill_data = r_fill_data;
        n_scr       = r_scr;
        n_rd        = r_rd;
        n_out_valid = r_out_valid & i_out_stall;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_out_off   = r_out_off;
        n_out_rd    = r_out_rd;
        n_out_scr   = r_out_scr;
        grid_ctl    = '0;
        waddr       = '0;
        wdata       = '0;
        raddr       = '0;

        if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_COLUMNS: n_columns = i_cfg_data;
                REG_ROWS:    n_rows    = i_cfg_data[ROW_W-1:0];
                default:     n_columns = r_columns;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = t_cmd'(i_cmd);
                    n_ch     = i_char_code;
                    n_col_in = i_col;
                    n_row_in = i_row;
                    n_scr    = 1'b0;
                    n_rd     = '0;
                    n_state  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_cur_col = col_s;
                n_cur_row = row_s;
                unique case (r_cmd)
                    CMD_PUT: begin
                        grid_ctl.we = put_we;
                        waddr       = AW'(lin);
                        wdata       = put_data;
                        n_cur_col   = put_col[COL_W-1:0];
                        n_cur_row   = put_row[ROW_W-1:0];
                        if (put_scroll) begin
                            n_scr   = 1'b1;
                            n_ra    = CW'(nc);
                            n_lim   = CW'(prod + LIN_W'(nc));
                            n_pend  = 1'b0;
                            n_state = ST_COPY;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                    CMD_MOVE: begin
                        n_cur_col = in_col_s;
                        n_cur_row = in_row_s;
                        n_state   = ST_DONE;
                    end
                    CMD_CLEAR: begin
                        n_cur_col   = '0;
                        n_cur_row   = '0;
                        n_ra        = '0;
                        n_lim       = CW'(DEPTH);
                        n_fill_data = '0;
                        n_after     = ST_DONE;
                        n_state     = ST_FILL;
                    end
                    CMD_READ: begin
                        grid_ctl.re = 1'b1;
                        raddr       = AW'(lin);
                        n_state     = ST_READ;
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_READ: begin
                n_rd    = rdata;
                n_state = ST_DONE;
            end
            ST_COPY: begin
                if (r_ra != r_lim) begin
                    grid_ctl.re = 1'b1;
                    raddr       = AW'(r_ra);
                    n_pa        = AW'(r_ra - CW'(nc));
                    n_pend      = 1'b1;
                    n_ra        = ra_inc;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    grid_ctl.we = 1'b1;
                    waddr       = r_pa;
                    wdata       = rdata;
                end
                if (r_ra == r_lim && !r_pend) begin
                    n_ra        = r_lim - CW'(nc);
                    n_fill_data = CH_SPACE;
                    n_after     = ST_DONE;
                    n_state     = ST_FILL;
                end
            end
            ST_FILL: begin
                grid_ctl.we = 1'b1;
                waddr       = AW'(r_ra);
                wdata       = r_fill_data;
                n_ra        = ra_inc;
                if (ra_inc == r_lim) begin
                    n_state = r_after;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_col   = r_cur_col;
                    n_out_row   = r_cur_row;
                    n_out_off   = lin[OFF_W-1:0];
                    n_out_rd    = r_rd;
                    n_out_scr   = r_scr;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_after     <= ST_IDLE;
            r_ra        <= '0;
            r_lim       <= CW'(DEPTH);
            r_fill_data <= '0;
            r_pend      <= 1'b0;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_columns   <= COLUMNS_RST;
            r_rows      <= ROWS_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_after     <= n_after;
            r_ra        <= n_ra;
            r_lim       <= n_lim;
            r_fill_data <= n_fill_data;
            r_pend      <= n_pend;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_columns   <= n_columns;
            r_rows      <= n_rows;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_ch      <= n_ch;
        r_col_in  <= n_col_in;
        r_row_in  <= n_row_in;
        r_pa      <= n_pa;
        r_scr     <= n_scr;
        r_rd      <= n_rd;
        r_out_col <= n_out_col;
        r_out_row <= n_out_row;
        r_out_off <= n_out_off;
        r_out_rd  <= n_out_rd;
        r_out_scr <= n_out_scr;
    end

    tcce_grid #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_grid (
        .i_clk   (i_clk),
        .i_ctl   (grid_ctl),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_cfg_ready     = 1'b1;
    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_cursor_col    = r_out_col;
    assign o_cursor_row    = r_out_row;
    assign o_cursor_offset = r_out_off;
    assign o_read_char     = r_out_rd;
    assign o_scrolled      = r_out_scr;

endmodule
